// ----- rtl/thresholded_centroid_core_defines.svh -----
// Assertion macros for the thresholded centroid core checker.
// Needs signals named clk and arst_n in the scope where a macro is used.
`ifndef THRESHOLDED_CENTROID_CORE_DEFINES_SVH
`define THRESHOLDED_CENTROID_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define TCC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TCC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/tcc_pkg.sv -----
// Shared constants and controller/datapath interface types for the
// thresholded centroid core. No dependencies.
package tcc_pkg;

	localparam int PIX_W     = 8;
	localparam int SIZE_W    = 13;
	localparam int SUM_W     = 36;
	localparam int COUNT_W   = 25;
	localparam int CENTER_W  = 16;
	localparam int CFG_IDX_W = 2;
	localparam int M_DATA_W  = ((2 * CENTER_W + COUNT_W + 7) / 8) * 8;

	localparam int MAX_WIDTH_DEF  = 4096;
	localparam int MAX_HEIGHT_DEF = 4096;
	localparam int FRAC_BITS_DEF  = 4;

	localparam logic [PIX_W-1:0] THRESH_RESET  = 8'h80;
	localparam int               WIDTH_RESET   = 640;
	localparam int               HEIGHT_RESET  = 480;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

	typedef struct packed {
		logic pix_take;   // pixel transfer this cycle
		logic div_start;  // the transfer closes the frame
	} tcc_cmd_t;

	typedef struct packed {
		logic frame_end;  // position sits on the last pixel of the frame
		logic div_done;   // centers ready in the output register next cycle
	} tcc_status_t;

endpackage

// ----- rtl/tcc_divider.sv -----
// Restoring divider, one quotient bit per cycle.
// Standalone; used by tcc_datapath.
module tcc_divider #(
	parameter int NUM_W = 40,
	parameter int DEN_W = 25
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] num_q;

	logic [DEN_W:0] trial;
	logic [DEN_W:0] diff;
	logic           fits;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			done_q <= (cnt_q == LAST);
			busy_q <= (cnt_q != LAST);
			cnt_q  <= cnt_q + 1'b1;
		end else begin
			done_q <= 1'b0;
		end
	end

	// quotient bits shift in at the bottom as the dividend shifts out the top
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			num_q <= {num_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = num_q;

endmodule

// ----- rtl/tcc_datapath.sv -----
// Datapath: size/threshold registers, raster position, running sums and count,
// two divider lanes and the result register. Depends on tcc_pkg, tcc_divider.
module tcc_datapath #(
	parameter int MAX_WIDTH  = tcc_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = tcc_pkg::MAX_HEIGHT_DEF,
	parameter int FRAC_BITS  = tcc_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic [tcc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tcc_pkg::SIZE_W-1:0]     cfg_data,
	input  logic [tcc_pkg::PIX_W-1:0]      pixel,
	input  tcc_pkg::tcc_cmd_t              cmd,
	output tcc_pkg::tcc_status_t           status,
	output logic [tcc_pkg::CENTER_W-1:0]   center_x,
	output logic [tcc_pkg::CENTER_W-1:0]   center_y,
	output logic [tcc_pkg::COUNT_W-1:0]    pixel_count,
	output logic                           empty_frame
);

	import tcc_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int NUM_W = SUM_W + FRAC_BITS;

	localparam int W_RST = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
	localparam int H_RST = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;
	localparam logic [COL_W-1:0]  COL_LAST_RST = COL_W'(W_RST - 1);
	localparam logic [ROW_W-1:0]  ROW_LAST_RST = ROW_W'(H_RST - 1);
	localparam logic [SIZE_W-1:0] MAX_W_S = SIZE_W'(MAX_WIDTH);
	localparam logic [SIZE_W-1:0] MAX_H_S = SIZE_W'(MAX_HEIGHT);

	logic [PIX_W-1:0]  thresh_q;
	logic [COL_W-1:0]  col_last_q;
	logic [ROW_W-1:0]  row_last_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [SUM_W-1:0]  sum_col_q;
	logic [SUM_W-1:0]  sum_row_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] count_snap_q;

	logic               hit;
	logic [SUM_W-1:0]   sum_col_nx;
	logic [SUM_W-1:0]   sum_row_nx;
	logic [COUNT_W-1:0] count_nx;
	logic [SIZE_W-1:0]  data_m1;
	logic [COL_W-1:0]   col_last_wr;
	logic [ROW_W-1:0]   row_last_wr;
	logic               row_end;
	logic               last_row;

	logic [NUM_W-1:0]   num_x;
	logic [NUM_W-1:0]   num_y;
	logic [NUM_W-1:0]   quo_x;
	logic [NUM_W-1:0]   quo_y;
	logic               done_x;
	logic               done_y;

	// zero acts as one, oversize acts as the maximum; stored as last index
	assign data_m1 = cfg_data - 1'b1;
	always_comb begin
		if (cfg_data == '0)
			col_last_wr = '0;
		else if (cfg_data > MAX_W_S)
			col_last_wr = COL_W'(MAX_WIDTH - 1);
		else
			col_last_wr = data_m1[COL_W-1:0];
		if (cfg_data == '0)
			row_last_wr = '0;
		else if (cfg_data > MAX_H_S)
			row_last_wr = ROW_W'(MAX_HEIGHT - 1);
		else
			row_last_wr = data_m1[ROW_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q   <= THRESH_RESET;
			col_last_q <= COL_LAST_RST;
			row_last_q <= ROW_LAST_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_THRESHOLD:    thresh_q   <= cfg_data[PIX_W-1:0];
				REG_FRAME_WIDTH:  col_last_q <= col_last_wr;
				REG_FRAME_HEIGHT: row_last_q <= row_last_wr;
				default: ;
			endcase
		end
	end

	assign hit        = pixel > thresh_q;
	assign sum_col_nx = hit ? sum_col_q + SUM_W'(col_q) : sum_col_q;
	assign sum_row_nx = hit ? sum_row_q + SUM_W'(row_q) : sum_row_q;
	assign count_nx   = hit ? count_q + 1'b1 : count_q;

	// >= so a size shrunk mid-frame still closes the row or frame
	assign row_end  = col_q >= col_last_q;
	assign last_row = row_q >= row_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			sum_col_q <= '0;
			sum_row_q <= '0;
			count_q   <= '0;
		end else if (cmd.pix_take) begin
			if (row_end && last_row) begin
				col_q     <= '0;
				row_q     <= '0;
				sum_col_q <= '0;
				sum_row_q <= '0;
				count_q   <= '0;
			end else begin
				sum_col_q <= sum_col_nx;
				sum_row_q <= sum_row_nx;
				count_q   <= count_nx;
				if (row_end) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	assign num_x = NUM_W'(sum_col_nx) << FRAC_BITS;
	assign num_y = NUM_W'(sum_row_nx) << FRAC_BITS;

	tcc_divider #(
		.NUM_W (NUM_W),
		.DEN_W (COUNT_W)
	) u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (num_x),
		.den    (count_nx),
		.done   (done_x),
		.quo    (quo_x)
	);

	tcc_divider #(
		.NUM_W (NUM_W),
		.DEN_W (COUNT_W)
	) u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (num_y),
		.den    (count_nx),
		.done   (done_y),
		.quo    (quo_y)
	);

	always_ff @(posedge clk) begin
		if (cmd.div_start)
			count_snap_q <= count_nx;
	end

	// result register; lanes run in lockstep, both done together
	always_ff @(posedge clk) begin
		if (done_x && done_y) begin
			pixel_count <= count_snap_q;
			empty_frame <= (count_snap_q == '0);
			if (count_snap_q == '0) begin
				center_x <= '0;
				center_y <= '0;
			end else begin
				center_x <= (|quo_x[NUM_W-1:CENTER_W]) ? '1 : quo_x[CENTER_W-1:0];
				center_y <= (|quo_y[NUM_W-1:CENTER_W]) ? '1 : quo_y[CENTER_W-1:0];
			end
		end
	end

	assign status.frame_end = row_end && last_row;
	assign status.div_done  = done_x;

endmodule

// ----- rtl/tcc_ctrl.sv -----
// Controller: stream handshakes, frame-end divide launch and result hold.
// Depends on tcc_pkg.
module tcc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	input  tcc_pkg::tcc_status_t  status,
	output tcc_pkg::tcc_cmd_t     cmd
);

	import tcc_pkg::*;

	typedef enum logic [1:0] {
		ST_RUN,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t state_q;
	logic   m_tvalid_q;
	logic   take;

	// mid-frame pixels flow in any state; the closing pixel waits for ST_RUN: no divide running, no result held
	assign s_tready      = (state_q == ST_RUN) || !status.frame_end;
	assign take          = s_tvalid && s_tready;
	assign cmd.pix_take  = take;
	assign cmd.div_start = take && status.frame_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_RUN;
			m_tvalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_RUN: begin
					if (cmd.div_start)
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (status.div_done) begin
						state_q    <= ST_OUT;
						m_tvalid_q <= 1'b1;
					end
				end
				ST_OUT: begin
					if (m_tready) begin
						state_q    <= ST_RUN;
						m_tvalid_q <= 1'b0;
					end
				end
				default: begin
					state_q    <= ST_RUN;
					m_tvalid_q <= 1'b0;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;

endmodule

// ----- rtl/thresholded_centroid_core.sv -----
// Thresholded image centroid: top level joining controller and datapath.
// Depends on tcc_pkg, tcc_ctrl, tcc_datapath, tcc_divider.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+----------------------------------------
//  s_      | in  | s_tvalid / s_tready | s_tdata: pixel
//  m_      | out | m_tvalid / m_tready | m_tdata: center_x, center_y, pixel_count
//          |     |                     | m_tuser: empty_frame
//  cfg_    | in  | cfg_valid/cfg_ready | cfg_index, cfg_data (always ready)
//
// One pixel per cycle while s_tready is high. The last pixel of a frame launches two
// restoring dividers; the result shows in the cycle after they finish.
// Pixels of the next frame keep flowing meanwhile; only its closing pixel stalls
// while the dividers run or a result still waits on m_tready.
// Reset clears position, sums and count and loads threshold 128, 640 x 480.
module thresholded_centroid_core #(
	parameter int MAX_WIDTH  = tcc_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = tcc_pkg::MAX_HEIGHT_DEF,
	parameter int FRAC_BITS  = tcc_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [tcc_pkg::PIX_W-1:0]      s_tdata,   // [7:0] pixel
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [tcc_pkg::M_DATA_W-1:0]   m_tdata,   // [15:0] center_x, [31:16] center_y,
	                                                  // [56:32] pixel_count, rest zero
	output logic                           m_tuser,   // [0] empty_frame
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tcc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tcc_pkg::SIZE_W-1:0]     cfg_data
);

	import tcc_pkg::*;

	localparam int PAD_W = M_DATA_W - 2 * CENTER_W - COUNT_W;

	tcc_cmd_t            cmd;
	tcc_status_t         status;
	logic [CENTER_W-1:0] center_x;
	logic [CENTER_W-1:0] center_y;
	logic [COUNT_W-1:0]  pixel_count;
	logic                empty_frame;

	tcc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	tcc_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.FRAC_BITS  (FRAC_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pixel       (s_tdata),
		.cmd         (cmd),
		.status      (status),
		.center_x    (center_x),
		.center_y    (center_y),
		.pixel_count (pixel_count),
		.empty_frame (empty_frame)
	);

	assign cfg_ready = 1'b1;
	assign m_tdata   = {PAD_W'(0), pixel_count, center_y, center_x};
	assign m_tuser   = empty_frame;

endmodule

// ----- rtl/tcc_checker.sv -----
// Port-level checker for thresholded_centroid_core, attached by bind below.
// Depends on tcc_pkg and thresholded_centroid_core_defines.svh.
`include "thresholded_centroid_core_defines.svh"

module tcc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [tcc_pkg::M_DATA_W-1:0]   m_tdata,
	input logic                           m_tuser
);

	// a stalled result holds its payload
	`TCC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

	// empty frame flag matches a zero count
	`TCC_ASSERT_NOW(a_empty_count, m_tvalid, m_tuser == (m_tdata[56:32] == 25'd0), "empty flag disagrees with count")

	// empty frame reports zero centers
	`TCC_ASSERT_NOW(a_empty_zero, m_tvalid && m_tuser, m_tdata[31:0] == 32'd0, "empty frame with nonzero center")

	// one result in flight: after a transfer the next needs a full divide
	`TCC_ASSERT_NEXT(a_one_result, m_tvalid && m_tready, !m_tvalid, "result repeated right after transfer")

endmodule

bind thresholded_centroid_core tcc_checker u_tcc_checker (.*);
